>>> rtl/core/lrai_pkg.sv
package lrai_pkg;
    localparam int NUM_REGS_DEF   = 26;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W  = 4;
    localparam int IDX_W = 5;
    localparam int IMM_W = 32;
    localparam int RES_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_IN   = 4'd0;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd1;
    localparam logic [OP_W-1:0] OP_MOV  = 4'd2;
    localparam logic [OP_W-1:0] OP_XCHG = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD  = 4'd4;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd7;
    localparam logic [OP_W-1:0] OP_MOD  = 4'd8;
    localparam logic [OP_W-1:0] OP_AND  = 4'd9;
    localparam logic [OP_W-1:0] OP_OR   = 4'd10;
    localparam logic [OP_W-1:0] OP_XOR  = 4'd11;

    // Decoded instruction handed from the front end to the execute side.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] x_idx;
        logic [IDX_W-1:0] y_idx;
        logic [IDX_W-1:0] sa;
        logic             is_div;
        logic [IMM_W-1:0] imm;
    } instr_t;
endpackage

>>> rtl/core/lrai_front.sv
module lrai_front
    import lrai_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [19:0]  in_bits,
    input  logic [31:0]  in_imm,
    output logic         q_valid,
    input  logic         q_ready,
    output instr_t       q_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    instr_t          mem_reg [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    instr_t          dec;
    logic            push, pop;
    logic            three;

    always_comb
    begin
        three      = in_bits[19];
        dec.op     = in_bits[3:0];
        dec.d      = in_bits[8:4];
        dec.sa     = in_bits[13:9];
        dec.x_idx  = three ? in_bits[13:9] : in_bits[8:4];
        dec.y_idx  = three ? in_bits[18:14] : in_bits[13:9];
        dec.is_div = (in_bits[3:0] == OP_DIV) || (in_bits[3:0] == OP_MOD);
        dec.imm    = in_imm;
    end

    assign in_ready = (cnt_reg != (PW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

>>> rtl/core/lrai_divider.sv
module lrai_divider
    import lrai_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, na_reg, nq_reg;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    assign shifted = {r_reg[W-1:0], q_reg[W-1]};
    assign trial   = shifted - {1'b0, d_reg};
    assign done    = busy_reg && (cnt_reg == '0);
    assign quo     = nq_reg ? (~q_reg + 1'b1) : q_reg;
    assign rem     = na_reg ? (~r_reg[W-1:0] + 1'b1) : r_reg[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            na_reg <= a[W-1];
            nq_reg <= a[W-1] ^ b[W-1];
            q_reg  <= a[W-1] ? (~a + 1'b1) : a;
            d_reg  <= b[W-1] ? (~b + 1'b1) : b;
            r_reg  <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (!trial[W])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end
endmodule

>>> rtl/core/lrai_back.sv
module lrai_back
    import lrai_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  instr_t       q_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  out_value,
    output logic         out_err
);
    localparam int W = DATA_WIDTH;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [W-1:0] rf_reg [NUM_REGS];
    logic [1:0]   state_reg;
    instr_t       ins_reg;
    logic [W-1:0] x_reg, y_reg, prod_reg;
    logic [31:0]  val_reg;
    logic         err_reg;
    logic [W-1:0] x, y, dv, sv, imm_w, alu, ev;
    logic         we;
    logic         dstart, ddone;
    logic [W-1:0] dq, dr;

    function automatic logic [W-1:0] rd(input logic [IDX_W-1:0] i);
        logic [W-1:0] v;
        v = '0;
        for (int k = 0; k < NUM_REGS; k++)
        begin
            if (int'(i) == k)
            begin
                v = rf_reg[k];
            end
        end
        return v;
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] i);
        return int'(i) < NUM_REGS;
    endfunction

    function automatic logic [31:0] ext(input logic [W-1:0] v);
        logic [W+31:0] t;
        t = {{32{v[W-1]}}, v};
        return t[31:0];
    endfunction

    always_comb
    begin
        logic [W+31:0] ie;
        ie    = {{W{q_data.imm[IMM_W-1]}}, q_data.imm};
        imm_w = ie[W-1:0];
        x     = rd(q_data.x_idx);
        y     = rd(q_data.y_idx);
        dv    = rd(q_data.d);
        sv    = rd(q_data.sa);
    end

    always_comb
    begin
        we  = 1'b1;
        alu = dv;
        unique case (q_data.op)
            OP_IN:  alu = imm_w;
            OP_MOV: alu = sv;
            OP_XCHG: alu = sv;
            OP_ADD: alu = x + y;
            OP_SUB: alu = x - y;
            OP_AND: alu = x & y;
            OP_OR:  alu = x | y;
            OP_XOR: alu = x ^ y;
            default: we = 1'b0;
        endcase
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_value = val_reg;
    assign out_err   = err_reg;
    assign dstart    = (state_reg == S_DIV) && (ins_reg.op == OP_DIV || ins_reg.op == OP_MOD)
                       && (prod_reg == '0) && (y_reg != '0) && !err_reg;
    assign ev        = (ins_reg.op == OP_DIV) ? dq : dr;

    lrai_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .a(x_reg), .b(y_reg),
        .done(ddone), .quo(dq), .rem(dr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= 1'b0;
            prod_reg  <= '0;
            for (int k = 0; k < NUM_REGS; k++)
            begin
                rf_reg[k] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ins_reg  <= q_data;
                        x_reg    <= x;
                        y_reg    <= y;
                        err_reg  <= 1'b0;
                        prod_reg <= '0;
                        if (q_data.op == OP_MUL)
                        begin
                            state_reg <= S_MUL;
                        end
                        else if (q_data.is_div)
                        begin
                            // prod_reg doubles as a started flag while dividing.
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            if (we && in_range(q_data.d))
                            begin
                                rf_reg[q_data.d] <= alu;
                            end
                            // Swapping a register with itself changes nothing.
                            if (q_data.op == OP_XCHG && in_range(q_data.sa)
                                && (q_data.sa != q_data.d))
                            begin
                                rf_reg[q_data.sa] <= dv;
                            end
                            val_reg   <= ext((we && in_range(q_data.d)) ? alu : dv);
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= x_reg * y_reg;
                    state_reg <= S_DIV;
                    ins_reg.op <= OP_MUL;
                end
                S_DIV:
                begin
                    if (ins_reg.op == OP_MUL)
                    begin
                        if (in_range(ins_reg.d))
                        begin
                            rf_reg[ins_reg.d] <= prod_reg;
                            val_reg <= ext(prod_reg);
                        end
                        else
                        begin
                            val_reg <= '0;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (y_reg == '0)
                    begin
                        err_reg   <= 1'b1;
                        val_reg   <= ext(rd(ins_reg.d));
                        state_reg <= S_OUT;
                    end
                    else if (dstart)
                    begin
                        prod_reg <= {{(W-1){1'b0}}, 1'b1};
                    end
                    else if (ddone)
                    begin
                        if (in_range(ins_reg.d))
                        begin
                            rf_reg[ins_reg.d] <= ev;
                            val_reg <= ext(ev);
                        end
                        else
                        begin
                            val_reg <= '0;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/letter_register_alu_interpreter_core.sv
// Executes decoded instructions on a file of NUM_REGS signed registers, all zero after
// reset. A two-entry queue decouples instruction intake from execution. Simple operations
// complete directly from idle, MUL passes through a multiply state, and DIV/MOD use the
// radix-2 shift-subtract divider; a zero divisor is flagged without starting the divider.
// The execute side takes its next instruction only after each result beat is accepted.
module letter_register_alu_interpreter_core
    import lrai_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[3:0], dest_reg[8:4], src_a_reg[13:9], src_b_reg[18:14],
    // three_operand[19], immediate[51:20], zero fill to 56 bits
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value[31:0]
    output logic [31:0] m_axis_tdata,
    // divide_error[0]
    output logic        m_axis_tuser
);
    logic   q_valid, q_ready;
    instr_t q_data;

    lrai_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_bits(s_axis_tdata[19:0]), .in_imm(s_axis_tdata[51:20]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    lrai_back #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(m_axis_tdata), .out_err(m_axis_tuser)
    );

    a_err_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (u_back.ins_reg.op == OP_DIV || u_back.ins_reg.op == OP_MOD))
        else $error("divide error on non-divide");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

>>> test/tb_letter_register_alu_interpreter_core.sv
`timescale 1ns / 100ps

module tb_letter_register_alu_interpreter_core;
    import lrai_pkg::*;

    typedef struct packed {
        logic [31:0]      immediate;
        logic             three_operand;
        logic [IDX_W-1:0] src_b_reg;
        logic [IDX_W-1:0] src_a_reg;
        logic [IDX_W-1:0] dest_reg;
        logic [OP_W-1:0]  operation;
    } instr_beat_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        divide_error;
    } result_t;

    localparam int NREG = 26;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    instr_beat_t pending_instrs[$];
    result_t     expected_results[$];
    logic [31:0] shadow_regs[NREG];
    int          error_count;
    int          instrs_sent;
    int          results_seen;
    int          src_gap;
    int          sink_gap;
    bit          stim_done;

    letter_register_alu_interpreter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] read_reg(logic [IDX_W-1:0] idx);
        return (idx < NREG) ? shadow_regs[idx] : 32'd0;
    endfunction

    function automatic void write_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
        if (idx < NREG)
            shadow_regs[idx] = v;
    endfunction

    // Executes one instruction on the shadow register file.
    function automatic result_t execute_instr(instr_beat_t in);
        logic [31:0] x, y, t, ua, ub, uq, ur, q, r;
        logic        err;
        result_t     res;
        err = 1'b0;
        x = in.three_operand ? read_reg(in.src_a_reg) : read_reg(in.dest_reg);
        y = in.three_operand ? read_reg(in.src_b_reg) : read_reg(in.src_a_reg);
        case (in.operation) inside
            OP_IN:   write_reg(in.dest_reg, in.immediate);
            OP_OUT:  ;
            OP_MOV:  write_reg(in.dest_reg, read_reg(in.src_a_reg));
            OP_XCHG:
            begin
                t = read_reg(in.dest_reg);
                write_reg(in.dest_reg, read_reg(in.src_a_reg));
                write_reg(in.src_a_reg, t);
            end
            OP_ADD:  write_reg(in.dest_reg, x + y);
            OP_SUB:  write_reg(in.dest_reg, x - y);
            OP_MUL:  write_reg(in.dest_reg, x * y);
            OP_DIV, OP_MOD:
            begin
                if (y == 32'd0)
                    err = 1'b1;
                else
                begin
                    ua = x[31] ? -x : x;
                    ub = y[31] ? -y : y;
                    uq = ua / ub;
                    ur = ua % ub;
                    q = (x[31] != y[31]) ? -uq : uq;
                    r = x[31] ? -ur : ur;
                    write_reg(in.dest_reg, (in.operation == OP_DIV) ? q : r);
                end
            end
            OP_AND:  write_reg(in.dest_reg, x & y);
            OP_OR:   write_reg(in.dest_reg, x | y);
            OP_XOR:  write_reg(in.dest_reg, x ^ y);
            default: ;
        endcase
        res.result_value = read_reg(in.dest_reg);
        res.divide_error = err;
        return res;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_beat_t make_instr(logic [OP_W-1:0] op, int d, int a, int b,
                                               int three, logic [31:0] imm);
        instr_beat_t in;
        in.operation = op;
        in.dest_reg = IDX_W'(d);
        in.src_a_reg = IDX_W'(a);
        in.src_b_reg = IDX_W'(b);
        in.three_operand = three[0];
        in.immediate = imm;
        return in;
    endfunction

    initial
    begin
        instr_beat_t in;
        int          r;
        // Directed: extremes, every operation, divide corner cases, bad codes and indexes.
        pending_instrs.push_back(make_instr(OP_IN, 0, 0, 0, 0, 32'h8000_0000));
        pending_instrs.push_back(make_instr(OP_IN, 1, 0, 0, 1, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(OP_IN, 25, 0, 0, 0, 32'h7FFF_FFFF));
        pending_instrs.push_back(make_instr(OP_DIV, 2, 0, 1, 1, 0));
        pending_instrs.push_back(make_instr(OP_MOD, 3, 0, 1, 1, 0));
        pending_instrs.push_back(make_instr(OP_DIV, 0, 4, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_MOD, 25, 4, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_IN, 4, 0, 0, 0, -7));
        pending_instrs.push_back(make_instr(OP_IN, 5, 0, 0, 0, 2));
        pending_instrs.push_back(make_instr(OP_DIV, 6, 4, 5, 1, 0));
        pending_instrs.push_back(make_instr(OP_MOD, 7, 4, 5, 1, 0));
        pending_instrs.push_back(make_instr(OP_ADD, 25, 25, 0, 1, 0));
        pending_instrs.push_back(make_instr(OP_SUB, 0, 1, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_MUL, 8, 25, 25, 1, 0));
        pending_instrs.push_back(make_instr(OP_AND, 9, 1, 0, 1, 0));
        pending_instrs.push_back(make_instr(OP_OR, 10, 4, 5, 1, 0));
        pending_instrs.push_back(make_instr(OP_XOR, 4, 1, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_MOV, 11, 4, 0, 1, 0));
        pending_instrs.push_back(make_instr(OP_XCHG, 11, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_XCHG, 5, 5, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_OUT, 11, 0, 0, 1, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(4'd12, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(4'd15, 31, 31, 31, 1, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(OP_MOV, 31, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_ADD, 2, 30, 31, 1, 0));
        for (int i = 0; i < 1200; i++)
        begin
            in = make_instr(OP_W'($urandom_range(0, 11)), $urandom_range(0, 25),
                            $urandom_range(0, 25), $urandom_range(0, 25),
                            $urandom_range(0, 1), rand_value());
            r = $urandom_range(0, 99);
            // Loads are common so the operands stay varied.
            if (r < 25)
                in.operation = OP_IN;
            else if (r < 27)
                in.operation = OP_W'($urandom_range(12, 15));
            if (r >= 95)
            begin
                in.dest_reg = IDX_W'($urandom_range(0, 31));
                in.src_a_reg = IDX_W'($urandom_range(0, 31));
                in.src_b_reg = IDX_W'($urandom_range(0, 31));
            end
            pending_instrs.push_back(in);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        error_count = 0;
        instrs_sent = 0;
        results_seen = 0;
        src_gap = 0;
        sink_gap = 0;
        foreach (shadow_regs[i])
            shadow_regs[i] = 32'd0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: each beat is presented after a random gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(execute_instr(s_axis_tdata[51:0]));
                instrs_sent++;
                src_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_instrs.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'd0, pending_instrs.pop_front()};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat and stalls the result side at random.
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: value %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (m_axis_tdata !== exp_res.result_value)
                    begin
                        $error("result_value expected %h actual %h",
                               exp_res.result_value, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_res.divide_error)
                    begin
                        $error("divide_error expected %b actual %b",
                               exp_res.divide_error, m_axis_tuser);
                        error_count++;
                    end
                end
                sink_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        wait (stim_done && rst_n);
        wait (pending_instrs.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        $display("Ran %0d instructions over all twelve operations, %0d results checked,",
                 instrs_sent, results_seen);
        $display("including zero divisors, overflow divides and out-of-range indexes.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/lrai_pkg.sv
rtl/core/lrai_front.sv
rtl/core/lrai_divider.sv
rtl/core/lrai_back.sv
rtl/core/letter_register_alu_interpreter_core.sv
test/tb_letter_register_alu_interpreter_core.sv
